// ----- hw/rtl/itr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_pkg: shared types and constants for integer_to_radix_text
// Digit and radix widths, the glyph table and the control structs that pass
// between the sequencer, the serial divider and the digit stack.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // divider status toward the sequencer
  typedef struct packed {
    logic done;     // one-cycle pulse: quotient and remainder are settled
    logic nonzero;  // quotient of the finished pass is not zero
  } div_stat_t;

  // digit stack commands from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    unique case (d)
      4'd0:  g = 8'h30;
      4'd1:  g = 8'h31;
      4'd2:  g = 8'h32;
      4'd3:  g = 8'h33;
      4'd4:  g = 8'h34;
      4'd5:  g = 8'h35;
      4'd6:  g = 8'h36;
      4'd7:  g = 8'h37;
      4'd8:  g = 8'h38;
      4'd9:  g = 8'h39;
      4'd10: g = 8'h41;
      4'd11: g = 8'h42;
      4'd12: g = 8'h43;
      4'd13: g = 8'h44;
      4'd14: g = 8'h45;
      default: g = 8'h46;
    endcase
    return g;
  endfunction

endpackage

// ----- hw/rtl/integer_to_radix_text.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text: signed integer to ASCII text, radix 2 to 16
// Converts one VALUE_BITS-bit integer per transaction into a run of ASCII
// characters, most significant digit first, last character flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_value) takes one integer per
//   transaction; in_ready is high only while no conversion is in progress.
//   Output channel (out_valid/out_ready/out_character/out_last) gives one
//   character per transaction; out_last marks the end of each number.
//   cfg_wr_en/cfg_wr_data set the radix; values below 2 or above 16 are
//   clamped. Write it only while the block is idle. Reset radix is 10.
//   Decimal negatives get a leading '-'; other radices read the bits as
//   unsigned.
// Flow:
//   Each digit costs one pass of a bit-serial divider. After all digits
//   are found, each digit character passes through S_READ, S_SHOW and
//   S_WAIT, and a leading '-' is loaded straight into the output register
//   as the last divider pass ends.
// Reset: synchronous, active low; clears the sequencer, divider control, the
//   digit stack pointer and the output valid, and sets the radix to 10.
// Stall: a pending character holds in the output register until out_ready;
//   conversion work waits meanwhile.
// ----------------------------------------------------------------------------
module integer_to_radix_text
  import itr_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [RADIX_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_character,
  output logic                  out_last
);

  localparam int PTR_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for an input transaction
    S_DIV  = 5'b00010,  // divider pass in flight
    S_READ = 5'b00100,  // pop issued to the digit stack
    S_SHOW = 5'b01000,  // popped digit loads the output register
    S_WAIT = 5'b10000   // character waits for the receiver
  } state_t;

  state_t              state_r, state_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic                minus_r, minus_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  // divider and stack hookup
  div_stat_t             div_stat;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  stk_ctrl_t             stk_ctrl;
  logic [DIGIT_W-1:0]    stk_digit;
  logic [PTR_W-1:0]      stk_depth;

  logic                  in_xact;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  assign in_ready = (state_r == S_IDLE);
  assign in_xact  = in_valid & in_ready;

  // sign only matters in decimal; the most negative value negates to itself,
  // which is its correct unsigned magnitude
  assign in_neg = (radix_r == RADIX_DEC) & in_value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

  // radix register with clamping on write
  always_comb begin
    radix_nxt = radix_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (cfg_wr_data > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = cfg_wr_data;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    minus_nxt     = minus_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    div_dividend  = div_quot;
    stk_ctrl      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          minus_nxt    = in_neg;
          div_start    = 1'b1;
          div_dividend = in_mag;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          if (div_stat.nonzero) begin
            // more digits: divide the quotient again
            div_start = 1'b1;
          end else if (minus_r) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            state_nxt     = S_WAIT;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        stk_ctrl.pop = 1'b1;
        state_nxt    = S_SHOW;
      end
      S_SHOW: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_glyph(stk_digit);
        out_last_nxt  = (stk_depth == '0);
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = (stk_depth == '0) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
      minus_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      out_valid_r <= out_valid_nxt;
      minus_r     <= minus_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  itr_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (radix_r),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  itr_digit_stack #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (stk_ctrl),
    .push_digit (div_rem),
    .pop_digit  (stk_digit),
    .depth      (stk_depth)
  );

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ----- hw/rtl/itr_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_divider: bit-serial restoring divider
// Divides a VALUE_BITS-bit word by the radix one dividend bit per cycle; the
// quotient shifts back into the dividend register.
// ----------------------------------------------------------------------------
module itr_divider
  import itr_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    radix,
  output div_stat_t             stat,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);

  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] num_r, num_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic                  nz_r, nz_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [RADIX_W-1:0] rem_sh;
  logic [RADIX_W-1:0] rem_sub;
  logic               ge;

  assign rem_sh  = {rem_r, num_r[VALUE_BITS-1]};
  assign ge      = (rem_sh >= radix);
  assign rem_sub = rem_sh - radix;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    nz_nxt   = nz_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      nz_nxt   = 1'b0;
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the radix, so four bits hold it
      rem_nxt = ge ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
      num_nxt = {num_r[VALUE_BITS-2:0], ge};
      nz_nxt  = nz_r | ge;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    nz_r  <= nz_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.done    = done_r;
  assign stat.nonzero = nz_r;
  assign quotient     = num_r;
  assign remainder    = rem_r;

endmodule

// ----- hw/rtl/itr_digit_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_digit_stack: last-in first-out store for digits
// Digits arrive least significant first and leave most significant first.
// ----------------------------------------------------------------------------
module itr_digit_stack
  import itr_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  stk_ctrl_t                        ctrl,
  input  logic [DIGIT_W-1:0]               push_digit,
  output logic [DIGIT_W-1:0]               pop_digit,
  output logic [$clog2(VALUE_BITS+1)-1:0]  depth
);

  localparam int PTR_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [DIGIT_W-1:0] mem [VALUE_BITS];
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [PTR_W-1:0]   ptr_dec;
  logic [DIGIT_W-1:0] rd_r;

  assign ptr_dec = ptr_r - 1'b1;

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctrl.push) begin
      ptr_nxt = ptr_r + 1'b1;
    end else if (ctrl.pop) begin
      ptr_nxt = ptr_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[ptr_r[ADDR_W-1:0]] <= push_digit;
    end
    if (ctrl.pop) begin
      rd_r <= mem[ptr_dec[ADDR_W-1:0]];
    end
  end

  assign pop_digit = rd_r;
  assign depth     = ptr_r;

endmodule
